// File: rtl/core/rinf_pkg.sv
// shared types and constants of the ramp integrate-and-fire neuron
package rinf_pkg;

  localparam int unsigned NumSynapsesDef = 64;
  localparam int unsigned WeightMaxDef   = 7;

  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned WeightW = 3;
  localparam int unsigned ThreshW = 9;
  localparam int unsigned PotW    = 9;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUsedW = PotW + 2;

  localparam logic [PotW-1:0] PotOutMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_ACCUMULATE  = 2'd0,
    OP_MARK        = 2'd1,
    OP_RESET       = 2'd2,
    OP_CLEAR_FLAGS = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IdxW-1:0]    idx;
    logic [WeightW-1:0] weight;
  } item_t;

endpackage

// File: rtl/core/rinf_ram.sv
// generic single-port-write, registered-read ram
module rinf_ram #(
  parameter int unsigned  Width = 8,
  parameter int unsigned  Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ramp_integrate_fire_neuron.sv
// top level of the ramp (no leak) integrate-and-fire neuron body
//
// Ramp neuron body with one ramp counter and one spike flag per input synapse.
// Each item on the slave stream carries an operation in tuser (accumulate,
// mark spike flag, reset counters and flags, clear flags) and a synapse index
// and weight in tdata. Accumulate raises the addressed counter by one while it
// is below the weight (limited to WEIGHT_MAX), so it saturates at the weight.
// Every item yields exactly one result: the body potential (running sum of all
// counters, shown saturated at 511), a fire bit (full sum at or above the
// fire threshold) and the addressed synapse's spike flag after the item.
// Accumulate and mark items whose index is at or beyond NUM_SYNAPSES change
// nothing, and any item with such an index reads a flag of 0. Throughput is
// one item per clock cycle while the result stream does not stall: the counter
// ram is read as the item is taken, the item's update is computed and written
// back together with the result register when stage one advances, and a
// write-back to the address the next item reads is forwarded. Per-entry valid
// bits clear all counters at once on a reset item, so no clearing pass is
// needed after reset. The user must write the threshold through the cfg port
// (always ready) only while the block is idle; the block does not enforce it.
module ramp_integrate_fire_neuron
  import rinf_pkg::*;
#(
  parameter int unsigned NUM_SYNAPSES = NumSynapsesDef,
  parameter int unsigned WEIGHT_MAX   = WeightMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: fire threshold
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ThreshW-1:0]  cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // synapse_index[5:0], synapse_weight[8:6], zero pad
  input  logic [OpW-1:0]      s_axis_tuser,  // operation[1:0]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // body_potential[8:0], fires[9], flag_value[10], pad
);

  // effective counter limit: the weight field cannot exceed its own range
  localparam int unsigned WeightFieldMax = (1 << WeightW) - 1;
  localparam int unsigned EffMax  = (WEIGHT_MAX < WeightFieldMax) ? WEIGHT_MAX : WeightFieldMax;
  localparam int unsigned CntW    = $clog2(EffMax + 1);
  localparam int unsigned AddrW   = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
  localparam int unsigned SumMax  = NUM_SYNAPSES * EffMax;
  localparam int unsigned SumW    = $clog2(SumMax + 1);
  localparam int unsigned SatW    = (SumW > PotW) ? SumW : PotW;
  localparam int unsigned CmpW    = (SatW > ThreshW) ? SatW : ThreshW;
  localparam int unsigned IdxExtW = ((AddrW > IdxW) ? AddrW : IdxW) + 1;

  // threshold register
  logic [ThreshW-1:0] thresh_q;

  // input stage
  item_t              in_item;
  logic               in_acc;
  logic               in_range;
  logic [IdxExtW-1:0] in_idx_ext;
  logic [AddrW-1:0]   raddr;

  logic               s1_valid_q;
  item_t              s1_item_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               s1_range_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic [CntW-1:0]    fwd_cnt_q;

  // neuron state
  logic [NUM_SYNAPSES-1:0] cnt_vld_q, cnt_vld_d;
  logic [NUM_SYNAPSES-1:0] flags_q, flags_d;
  logic [SumW-1:0]         sum_q, sum_d;

  // update path
  logic               adv;
  logic [CntW-1:0]    ram_rdata;
  logic [CntW-1:0]    cnt_old;
  logic [CntW-1:0]    cnt_new;
  logic [CntW-1:0]    w_lim;
  logic               inc;
  logic               wr_en;
  logic [SatW-1:0]    sum_ext;
  logic [PotW-1:0]    pot_out;
  logic               fires_out;
  logic               flag_out;

  // result register
  logic               m_valid_q;
  logic [PotW-1:0]    m_pot_q;
  logic               m_fires_q;
  logic               m_flag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // handshake: stage one moves on whenever the result register is free
  assign adv           = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_item.op     = op_e'(s_axis_tuser);
  assign in_item.idx    = s_axis_tdata[IdxW-1:0];
  assign in_item.weight = s_axis_tdata[IdxW +: WeightW];

  assign in_idx_ext = IdxExtW'(in_item.idx);
  assign in_range   = in_idx_ext < IdxExtW'(NUM_SYNAPSES);
  // out-of-range items read entry zero, the data is ignored
  assign raddr      = in_range ? in_idx_ext[AddrW-1:0] : '0;

  // a write-back to the address being read this cycle bypasses the ram
  assign fwd_hit_d = wr_en && (s1_addr_q == raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= fwd_hit_d;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q  <= in_item;
      s1_addr_q  <= raddr;
      s1_range_q <= in_range;
      fwd_cnt_q  <= cnt_new;
    end
  end

  rinf_ram #(
    .Width(CntW),
    .Depth(NUM_SYNAPSES)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_addr_q),
    .wdata_i(cnt_new),
    .re_i   (in_acc),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // counter update of the item in stage one
  always_comb begin
    if (fwd_hit_q) begin
      cnt_old = fwd_cnt_q;
    end else if (cnt_vld_q[s1_addr_q]) begin
      cnt_old = ram_rdata;
    end else begin
      cnt_old = '0;
    end

    if (s1_item_q.weight > WeightW'(EffMax)) begin
      w_lim = CntW'(EffMax);
    end else begin
      w_lim = s1_item_q.weight[CntW-1:0];
    end

    inc     = (s1_item_q.op == OP_ACCUMULATE) && s1_range_q && (cnt_old < w_lim);
    cnt_new = cnt_old + CntW'(1);
  end

  assign wr_en = adv && inc;

  // state update
  always_comb begin
    cnt_vld_d = cnt_vld_q;
    flags_d   = flags_q;
    sum_d     = sum_q;
    case (s1_item_q.op)
      OP_ACCUMULATE: begin
        if (inc) begin
          cnt_vld_d[s1_addr_q] = 1'b1;
          sum_d                = sum_q + SumW'(1);
        end
      end
      OP_MARK: begin
        if (s1_range_q) begin
          flags_d[s1_addr_q] = 1'b1;
        end
      end
      OP_RESET: begin
        cnt_vld_d = '0;
        flags_d   = '0;
        sum_d     = '0;
      end
      OP_CLEAR_FLAGS: begin
        flags_d = '0;
      end
      default: begin
        flags_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      flags_q   <= '0;
      sum_q     <= '0;
    end else if (adv) begin
      cnt_vld_q <= cnt_vld_d;
      flags_q   <= flags_d;
      sum_q     <= sum_d;
    end
  end

  // result fields
  assign sum_ext   = SatW'(sum_d);
  assign pot_out   = (sum_ext > SatW'(PotOutMax)) ? PotOutMax : sum_ext[PotW-1:0];
  assign fires_out = CmpW'(sum_d) >= CmpW'(thresh_q);
  assign flag_out  = s1_range_q ? flags_d[s1_addr_q] : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_pot_q   <= pot_out;
      m_fires_q <= fires_out;
      m_flag_q  <= flag_out;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutUsedW){1'b0}}, m_flag_q, m_fires_q, m_pot_q};

`ifndef SYNTH
  // running sum never exceeds what the counters can hold
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumW'(SumMax))
    else $error("potential sum above counter capacity");

  // a reset item leaves every counter and flag cleared
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_item_q.op == OP_RESET) |=>
      (cnt_vld_q == '0 && flags_q == '0 && sum_q == '0))
    else $error("reset item did not clear state");

  // a counted accumulate moves the sum by exactly one
  a_sum_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (sum_q == $past(sum_q) + SumW'(1)))
    else $error("sum not advanced by accumulate");

  // a forwarded counter only exists for an item held in stage one
  a_fwd_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forward flag without item");
`endif

endmodule
